// ===== hw/rtl/csa_pkg.sv =====
`default_nettype none

package csa_pkg;

	// fixed field widths of the item and result channels
	localparam int unsigned COL_W      = 4;
	localparam int unsigned IN_VALUE_W = 32;
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned MASK_W     = 16;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = MASK_W;

	localparam logic [CFG_IDX_W-1:0] REG_STATS_EN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORDER_EN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED   = 2'd2;

	// parameter defaults
	localparam int unsigned COLUMNS_DEF    = 16;
	localparam int unsigned VALUE_BITS_DEF = 32;

	// slots of the per-column value record
	localparam int unsigned NUM_VALS = 5;
	localparam int unsigned VAL_LOW  = 0;
	localparam int unsigned VAL_HIGH = 1;
	localparam int unsigned VAL_BEST = 2;
	localparam int unsigned VAL_G1   = 3;
	localparam int unsigned VAL_G2   = 4;

	typedef struct packed {
		logic [COL_W-1:0]      column;
		logic [IN_VALUE_W-1:0] value;
		logic                  is_null;
	} csa_item_t;

	typedef struct packed {
		logic [COL_W-1:0]      out_column;
		logic [CNT_W-1:0]      null_count;
		logic [CNT_W-1:0]      nonnull_count;
		logic [IN_VALUE_W-1:0] min_value;
		logic [CNT_W-1:0]      min_count;
		logic [IN_VALUE_W-1:0] max_value;
		logic [CNT_W-1:0]      max_count;
		logic [IN_VALUE_W-1:0] common_value;
		logic [CNT_W-1:0]      common_count;
		logic                  has_value;
	} csa_result_t;

	// per-column counters, one memory word
	typedef struct packed {
		logic             seen;
		logic [CNT_W-1:0] nulls;
		logic [CNT_W-1:0] nonnulls;
		logic [CNT_W-1:0] low_hits;
		logic [CNT_W-1:0] high_hits;
		logic [CNT_W-1:0] best_hits;
		logic [CNT_W-1:0] g1_total;
		logic [CNT_W-1:0] g1_recent;
		logic [CNT_W-1:0] g2_recent;
	} csa_counts_t;

	typedef struct packed {
		logic enabled;
		logic ordered;
		logic sgn;
		logic is_null;
	} csa_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csa_update.sv =====
`default_nettype none

module csa_update #(
	parameter int unsigned VALUE_BITS = csa_pkg::VALUE_BITS_DEF
) (
	input  wire csa_pkg::csa_ctrl_t                                 ctrl,
	input  wire logic [VALUE_BITS-1:0]                              v,
	input  wire csa_pkg::csa_counts_t                               cnt_cur,
	input  wire logic [csa_pkg::NUM_VALS-1:0][VALUE_BITS-1:0]       val_cur,
	output csa_pkg::csa_counts_t                                    cnt_nxt,
	output logic [csa_pkg::NUM_VALS-1:0][VALUE_BITS-1:0]            val_nxt
);

	localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [csa_pkg::CNT_W-1:0] CNT_ONE = {{(csa_pkg::CNT_W-1){1'b0}}, 1'b1};

	function automatic logic [csa_pkg::CNT_W-1:0] sat_inc(input logic [csa_pkg::CNT_W-1:0] x);
		sat_inc = (&x) ? x : x + CNT_ONE;
	endfunction

	function automatic logic less(input logic [VALUE_BITS-1:0] a,
			input logic [VALUE_BITS-1:0] b, input logic sgn);
		logic [VALUE_BITS-1:0] flip;
		flip = sgn ? SIGN_BIT : '0;
		less = (a ^ flip) < (b ^ flip);
	endfunction

	csa_pkg::csa_counts_t                              c;
	logic [csa_pkg::NUM_VALS-1:0][VALUE_BITS-1:0]      vals;
	logic                                              hit;
	logic [VALUE_BITS-1:0]                             tv;
	logic [csa_pkg::CNT_W-1:0]                         tc;

	always_comb begin
		c    = cnt_cur;
		vals = val_cur;
		hit  = 1'b1;
		tv   = '0;
		tc   = '0;
		if (ctrl.enabled) begin
			if (ctrl.is_null) begin
				c.nulls = sat_inc(c.nulls);
			end else begin
				c.nonnulls = sat_inc(c.nonnulls);
				// first value seeds every bucket
				if (!c.seen) begin
					vals[csa_pkg::VAL_BEST] = v;
					vals[csa_pkg::VAL_G1]   = v;
					vals[csa_pkg::VAL_G2]   = v;
					vals[csa_pkg::VAL_LOW]  = v;
					vals[csa_pkg::VAL_HIGH] = v;
					c.best_hits = '0;
					c.g1_total  = CNT_ONE;
					c.g1_recent = CNT_ONE;
					c.g2_recent = CNT_ONE;
					c.low_hits  = '0;
					c.high_hits = '0;
					c.seen      = 1'b1;
				end
				if (ctrl.ordered) begin
					if (less(v, vals[csa_pkg::VAL_LOW], ctrl.sgn)) begin
						vals[csa_pkg::VAL_LOW] = v;
						c.low_hits = CNT_ONE;
					end else if (v == vals[csa_pkg::VAL_LOW]) begin
						c.low_hits = sat_inc(c.low_hits);
					end
					if (less(vals[csa_pkg::VAL_HIGH], v, ctrl.sgn)) begin
						vals[csa_pkg::VAL_HIGH] = v;
						c.high_hits = CNT_ONE;
					end else if (v == vals[csa_pkg::VAL_HIGH]) begin
						c.high_hits = sat_inc(c.high_hits);
					end
				end
				if (v == vals[csa_pkg::VAL_BEST]) begin
					c.best_hits = sat_inc(c.best_hits);
				end else if (v == vals[csa_pkg::VAL_G1]) begin
					c.g1_total  = sat_inc(c.g1_total);
					c.g1_recent = sat_inc(c.g1_recent);
				end else if (v == vals[csa_pkg::VAL_G2]) begin
					c.g2_recent = sat_inc(c.g2_recent);
				end else begin
					hit = 1'b0;
				end
				// second guess overtakes first guess
				if (c.g2_recent > c.g1_recent) begin
					tv = vals[csa_pkg::VAL_G1];
					vals[csa_pkg::VAL_G1] = vals[csa_pkg::VAL_G2];
					vals[csa_pkg::VAL_G2] = tv;
					tc = c.g1_recent;
					c.g1_recent = c.g2_recent;
					c.g2_recent = tc;
					c.g1_total  = c.g1_recent;
				end
				// first guess overtakes best
				if (c.g1_total > c.best_hits) begin
					tv = vals[csa_pkg::VAL_BEST];
					vals[csa_pkg::VAL_BEST] = vals[csa_pkg::VAL_G1];
					vals[csa_pkg::VAL_G1] = tv;
					tc = c.best_hits;
					c.best_hits = c.g1_total;
					c.g1_total  = tc;
					c.g1_recent = CNT_ONE;
					c.g2_recent = CNT_ONE;
				end
				// miss replaces the second guess
				if (!hit) begin
					vals[csa_pkg::VAL_G2] = v;
					c.g1_recent = CNT_ONE;
					c.g2_recent = CNT_ONE;
				end
			end
		end
		cnt_nxt = c;
		val_nxt = vals;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/column_stats_accumulator.sv =====
`default_nettype none

// column statistics accumulator
// item channel (item_valid/item_ready/item): one column value per request, with
//   the column index, the raw value and a null flag
// result channel (result_valid/result_ready/result): one request per item with
//   the updated statistics of that column, in item order
// config port (cfg_we/cfg_index/cfg_data): register 0 selects gathered columns,
//   register 1 columns with min/max tracking, register 2 signed ordering;
//   write only while no item is in flight
// result path: the item and its memory read are registered in the read stage,
//   then the updated statistics are registered into the result register
// throughput: one item per cycle while results are taken, also when consecutive
//   items hit the same column; the per-column record sits in two memories with a
//   registered read, read when the item is accepted and written back when it
//   leaves the read stage; the last write is forwarded to the next same-column read
// reset: masks go to all ones; per-column valid flags clear so every column
//   reads as all zero statistics at once, no clearing pass is needed
// stall: the result register holds until taken; one more item waits in the
//   read stage, and item_ready falls only when both are full
module column_stats_accumulator #(
	parameter int unsigned COLUMNS    = csa_pkg::COLUMNS_DEF,
	parameter int unsigned VALUE_BITS = csa_pkg::VALUE_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   item_valid,
	output logic                                  item_ready,
	input  wire csa_pkg::csa_item_t               item,
	output logic                                  result_valid,
	input  wire                                   result_ready,
	output csa_pkg::csa_result_t                  result,
	input  wire                                   cfg_we,
	input  wire logic [csa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [csa_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned IDX_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int unsigned COL_SPAN = 1 << csa_pkg::COL_W;

	typedef logic [csa_pkg::NUM_VALS-1:0][VALUE_BITS-1:0] vals_t;

	// configuration registers
	logic [csa_pkg::MASK_W-1:0] stats_en_q;
	logic [csa_pkg::MASK_W-1:0] order_en_q;
	logic [csa_pkg::MASK_W-1:0] signed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_en_q <= '1;
			order_en_q <= '1;
			signed_q   <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csa_pkg::REG_STATS_EN: stats_en_q <= cfg_data;
				csa_pkg::REG_ORDER_EN: order_en_q <= cfg_data;
				csa_pkg::REG_SIGNED:   signed_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// request side
	logic             accept;
	logic [IDX_W-1:0] item_addr;
	logic             item_in_range;

	assign accept        = item_valid && item_ready;
	assign item_addr     = IDX_W'(item.column);
	assign item_in_range = (COLUMNS >= COL_SPAN) || (int'(item.column) < COLUMNS);

	// record memories and valid flags
	csa_pkg::csa_counts_t cnt_mem [COLUMNS];
	vals_t                val_mem [COLUMNS];
	logic [COLUMNS-1:0]   vld_q;

	// read stage
	logic                 valid_s1;
	csa_pkg::csa_item_t   item_s1;
	logic [IDX_W-1:0]     addr_s1;
	logic                 in_range_s1;
	csa_pkg::csa_counts_t cnt_rd_s1;
	vals_t                val_rd_s1;
	logic                 vld_rd_s1;

	// last write back, for same-column back to back items
	logic                 fwd_valid_q;
	logic [IDX_W-1:0]     fwd_addr_q;
	csa_pkg::csa_counts_t fwd_cnt_q;
	vals_t                fwd_val_q;

	logic                 adv_s1;
	logic                 wr_en;
	logic                 fwd_hit;
	csa_pkg::csa_counts_t cnt_cur;
	vals_t                val_cur;
	csa_pkg::csa_counts_t cnt_nxt;
	vals_t                val_nxt;
	csa_pkg::csa_ctrl_t   ctrl;
	csa_pkg::csa_result_t res;

	logic                 result_valid_q;
	csa_pkg::csa_result_t result_q;

	// read stage moves on when the result register is free or being emptied
	assign adv_s1     = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv_s1;
	assign wr_en      = adv_s1 && in_range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			fwd_valid_q    <= 1'b0;
			vld_q          <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (wr_en) begin
				fwd_valid_q    <= 1'b1;
				vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	// memory read on accept, write back when the read stage retires
	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_rd_s1 <= cnt_mem[item_addr];
			val_rd_s1 <= val_mem[item_addr];
		end
		if (wr_en) begin
			cnt_mem[addr_s1] <= cnt_nxt;
			val_mem[addr_s1] <= val_nxt;
		end
	end

	// stage payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= item;
			addr_s1     <= item_addr;
			in_range_s1 <= item_in_range;
			vld_rd_s1   <= vld_q[item_addr];
		end
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_cnt_q  <= cnt_nxt;
			fwd_val_q  <= val_nxt;
		end
		if (adv_s1) begin
			result_q <= res;
		end
	end

	// current record: forwarded write, else memory word, else reset value
	assign fwd_hit = fwd_valid_q && (fwd_addr_q == addr_s1);

	always_comb begin
		if (fwd_hit) begin
			cnt_cur = fwd_cnt_q;
			val_cur = fwd_val_q;
		end else if (vld_rd_s1) begin
			cnt_cur = cnt_rd_s1;
			val_cur = val_rd_s1;
		end else begin
			cnt_cur = '0;
			val_cur = '0;
		end
	end

	assign ctrl.enabled = stats_en_q[item_s1.column];
	assign ctrl.ordered = order_en_q[item_s1.column];
	assign ctrl.sgn     = signed_q[item_s1.column];
	assign ctrl.is_null = item_s1.is_null;

	csa_update #(
		.VALUE_BITS (VALUE_BITS)
	) u_update (
		.ctrl    (ctrl),
		.v       (VALUE_BITS'(item_s1.value)),
		.cnt_cur (cnt_cur),
		.val_cur (val_cur),
		.cnt_nxt (cnt_nxt),
		.val_nxt (val_nxt)
	);

	// result formatting; min/max read zero on unordered columns
	always_comb begin
		res            = '0;
		res.out_column = item_s1.column;
		if (in_range_s1) begin
			res.null_count    = cnt_nxt.nulls;
			res.nonnull_count = cnt_nxt.nonnulls;
			res.common_value  = csa_pkg::IN_VALUE_W'(val_nxt[csa_pkg::VAL_BEST]);
			res.common_count  = cnt_nxt.best_hits;
			res.has_value     = cnt_nxt.seen;
			if (ctrl.ordered) begin
				res.min_value = csa_pkg::IN_VALUE_W'(val_nxt[csa_pkg::VAL_LOW]);
				res.min_count = cnt_nxt.low_hits;
				res.max_value = csa_pkg::IN_VALUE_W'(val_nxt[csa_pkg::VAL_HIGH]);
				res.max_count = cnt_nxt.high_hits;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// an accepted request always occupies the read stage next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request missing from read stage");

	// the read stage only holds while the result register is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> (result_valid_q && !result_ready))
		else $error("read stage stalled without back pressure");

	// a written column is marked valid
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> vld_q[$past(addr_s1)])
		else $error("written column not marked valid");

	// a new result only comes from a retiring read stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(adv_s1))
		else $error("result appeared without a retiring request");

endmodule

`default_nettype wire
